FILE: rtl/csvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_pkg: shared types and constants for the CSV record tokeniser
// Transaction payloads, event kinds, parse modes and character codes.
// ----------------------------------------------------------------------------
package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [7:0] COL_MAX  = 8'hFF;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_CONTENT      = 3'd0;
    localparam t_kind KIND_FIELD_END    = 3'd1;
    localparam t_kind KIND_RECORD_END   = 3'd2;
    localparam t_kind KIND_UNTERMINATED = 3'd3;
    localparam t_kind KIND_MALFORMED    = 3'd4;
    localparam t_kind KIND_DONE         = 3'd5;

    typedef enum logic [1:0] {
        MODE_OPEN,
        MODE_QUOTED,
        MODE_CLOSED
    } t_mode;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] content_byte;
        logic [7:0] column_number;
        logic       last_of_run;
    } t_out;

    // One or two events raised by a single input transaction
    typedef struct packed {
        logic       two_events;
        t_kind      kind0;
        t_kind      kind1;
        logic [7:0] content_byte;
        logic [7:0] column_number;
    } t_bundle;

endpackage

FILE: rtl/csvt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_front: byte classifier and parse state
// Accepts one text byte per cycle while i_accept is high, updates the parse
// state and raises the events for that byte as one bundle.
// ----------------------------------------------------------------------------
module csvt_front
    import csvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_in     i_data,
    output logic    o_push,
    output t_bundle o_bundle
);

    t_mode      r_mode,      n_mode;
    logic       r_quote_pend, n_quote_pend;
    logic       r_skip_lf,   n_skip_lf;
    logic       r_has_chars, n_has_chars;
    logic [7:0] r_fields,    n_fields;
    logic       r_err,       n_err;

    logic [7:0] w_c;
    logic       w_term;
    logic       w_lf_swallow;
    logic       w_dbl_quote;
    t_mode      w_mode_eff;
    logic       w_open_rec;
    logic       w_quote_opens;
    logic       w_line_end;
    logic [1:0] w_count;

    assign w_c           = i_data.text_byte;
    assign w_term        = i_data.end_of_text || (w_c == CH_NUL);
    assign w_lf_swallow  = r_skip_lf && (w_c == CH_LF);
    assign w_dbl_quote   = r_quote_pend && (w_c == CH_QUOTE);
    assign w_mode_eff    = r_quote_pend ? MODE_CLOSED : r_mode;
    assign w_open_rec    = (r_fields != 8'd0) || r_has_chars;
    assign w_quote_opens = (w_c == CH_QUOTE) && (w_mode_eff != MODE_CLOSED) && !r_has_chars;
    assign w_line_end    = (w_c == CH_CR) || (w_c == CH_LF);

    // Next state
    always_comb begin
        n_mode       = r_mode;
        n_quote_pend = r_quote_pend;
        n_skip_lf    = r_skip_lf;
        n_has_chars  = r_has_chars;
        n_fields     = r_fields;
        n_err        = r_err;
        if (w_term) begin
            n_mode       = MODE_OPEN;
            n_quote_pend = 1'b0;
            n_skip_lf    = 1'b0;
            n_has_chars  = 1'b0;
            n_fields     = 8'd0;
            n_err        = 1'b0;
        end else if (r_err) begin
            n_err = 1'b1;
        end else if (w_lf_swallow) begin
            n_skip_lf = 1'b0;
        end else if (w_dbl_quote) begin
            n_skip_lf    = 1'b0;
            n_quote_pend = 1'b0;
            n_has_chars  = 1'b1;
        end else begin
            n_skip_lf    = 1'b0;
            n_quote_pend = 1'b0;
            n_mode       = w_mode_eff;
            if (w_mode_eff == MODE_QUOTED) begin
                if (w_c == CH_QUOTE) begin
                    n_quote_pend = 1'b1;
                end else begin
                    n_has_chars = 1'b1;
                end
            end else if (w_quote_opens) begin
                n_mode = MODE_QUOTED;
            end else if (w_c == CH_COMMA) begin
                if (r_fields != COL_MAX) begin
                    n_fields = r_fields + 8'd1;
                end
                n_has_chars = 1'b0;
                n_mode      = MODE_OPEN;
            end else if (w_line_end) begin
                n_fields    = 8'd0;
                n_has_chars = 1'b0;
                n_mode      = MODE_OPEN;
                n_skip_lf   = (w_c == CH_CR);
            end else if ((w_mode_eff == MODE_CLOSED) || (w_c == CH_QUOTE)) begin
                n_err = 1'b1;
            end else begin
                n_has_chars = 1'b1;
            end
        end
    end

    // Events for the current byte
    always_comb begin
        w_count                = 2'd0;
        o_bundle.kind0         = KIND_DONE;
        o_bundle.kind1         = KIND_DONE;
        o_bundle.content_byte  = 8'd0;
        o_bundle.column_number = r_fields;
        if (w_term) begin
            if (r_err) begin
                w_count = 2'd1;
            end else if ((r_mode == MODE_QUOTED) && !r_quote_pend) begin
                w_count        = 2'd2;
                o_bundle.kind0 = KIND_UNTERMINATED;
            end else if (w_open_rec) begin
                w_count        = 2'd2;
                o_bundle.kind0 = KIND_FIELD_END;
            end else begin
                w_count = 2'd1;
            end
        end else if (r_err || w_lf_swallow) begin
            w_count = 2'd0;
        end else if (w_dbl_quote) begin
            w_count               = 2'd1;
            o_bundle.kind0        = KIND_CONTENT;
            o_bundle.content_byte = CH_QUOTE;
        end else if (w_mode_eff == MODE_QUOTED) begin
            if (w_c != CH_QUOTE) begin
                w_count               = 2'd1;
                o_bundle.kind0        = KIND_CONTENT;
                o_bundle.content_byte = w_c;
            end
        end else if (w_quote_opens) begin
            w_count = 2'd0;
        end else if (w_c == CH_COMMA) begin
            w_count        = 2'd1;
            o_bundle.kind0 = KIND_FIELD_END;
        end else if (w_line_end) begin
            if (w_open_rec) begin
                w_count        = 2'd2;
                o_bundle.kind0 = KIND_FIELD_END;
                o_bundle.kind1 = KIND_RECORD_END;
            end
        end else if ((w_mode_eff == MODE_CLOSED) || (w_c == CH_QUOTE)) begin
            w_count        = 2'd1;
            o_bundle.kind0 = KIND_MALFORMED;
        end else begin
            w_count               = 2'd1;
            o_bundle.kind0        = KIND_CONTENT;
            o_bundle.content_byte = w_c;
        end
        o_bundle.two_events = (w_count == 2'd2);
    end

    assign o_push = i_accept && (w_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_OPEN;
            r_quote_pend <= 1'b0;
            r_skip_lf    <= 1'b0;
            r_has_chars  <= 1'b0;
            r_fields     <= 8'd0;
            r_err        <= 1'b0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_quote_pend <= n_quote_pend;
            r_skip_lf    <= n_skip_lf;
            r_has_chars  <= n_has_chars;
            r_fields     <= n_fields;
            r_err        <= n_err;
        end
    end

endmodule

FILE: rtl/csvt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_queue: event bundle queue
// Short first-in first-out queue between the classifier and the serialiser.
// ----------------------------------------------------------------------------
module csvt_queue
    import csvt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output t_bundle o_data,
    output logic    o_full,
    output logic    o_empty
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [IW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/csvt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_back: event serialiser
// Takes bundles from the queue and issues their events one per output
// transaction through a registered output stage.
// ----------------------------------------------------------------------------
module csvt_back
    import csvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bundle i_bundle,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_out    o_data
);

    logic       r_valid;
    t_out       r_data;
    logic       r_hold;
    t_kind      r_kind1;
    logic       w_free;

    assign w_free  = !r_valid || !i_stall;
    assign o_pop   = w_free && !r_hold && !i_empty;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hold  <= 1'b0;
        end else if (w_free) begin
            if (r_hold) begin
                r_valid <= 1'b1;
                r_hold  <= 1'b0;
            end else begin
                r_valid <= !i_empty;
                r_hold  <= !i_empty && i_bundle.two_events;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_hold) begin
                r_data.event_kind   <= r_kind1;
                r_data.content_byte <= 8'd0;
                r_data.last_of_run  <= 1'b1;
            end else begin
                r_data.event_kind    <= i_bundle.kind0;
                r_data.content_byte  <= i_bundle.content_byte;
                r_data.column_number <= i_bundle.column_number;
                r_data.last_of_run   <= !i_bundle.two_events;
                r_kind1              <= i_bundle.kind1;
            end
        end
    end

endmodule

FILE: rtl/csv_record_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_record_tokenizer: streaming CSV record tokeniser
// Turns CSV text bytes into content, field end, record end, error and done
// events.
// ----------------------------------------------------------------------------
// One text byte is accepted per clock cycle while the queue is not full. Each
// byte raises zero, one or two events. The events wait in a short bundle queue
// and leave through a registered output stage at one event per cycle while the
// output is not stalled. The sustained rate is therefore one byte per cycle,
// unless the text holds many bytes that raise two events, whose events leave
// one at a time. Line ends that close a record raise two events, and so do
// terminators that close an open record or an unterminated quote. The first
// event of a byte is written into the bundle queue and then into the output
// register before it is offered on the output. The input stalls only while the
// queue of QUEUE_DEPTH bundles is full.
module csv_record_tokenizer
    import csvt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic    w_accept;
    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_bundle w_front_bundle;
    t_bundle w_queue_bundle;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    csvt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_data   (i_in_data),
        .o_push   (w_push),
        .o_bundle (w_front_bundle)
    );

    csvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_bundle),
        .i_pop   (w_pop),
        .o_data  (w_queue_bundle),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    csvt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bundle (w_queue_bundle),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_data   (o_out_data)
    );

endmodule

FILE: dv/csv_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_event_checker: event predictor and scoreboard for the CSV tokeniser
// Watches both channels. Each accepted text transaction is run through a
// behavioural tokeniser that queues the events it should raise; each accepted
// event transaction is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module csv_event_checker
    import csvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out_data,
    output int unsigned o_fail_count,
    output int unsigned o_events_outstanding
);

    t_mode       mode;
    logic        quote_pending;
    logic        skip_lf;
    logic        has_chars;
    logic [7:0]  column;
    logic        err_latched;

    t_out        expected_events[$];
    t_out        want;
    int unsigned emitted;
    int unsigned fails;

    initial begin
        fails = 0;
    end

    function automatic void clear_parse_state();
        mode          = MODE_OPEN;
        quote_pending = 1'b0;
        skip_lf       = 1'b0;
        has_chars     = 1'b0;
        column        = 8'h00;
        err_latched   = 1'b0;
    endfunction

    function automatic void emit(input t_kind kind, input logic [7:0] ch);
        t_out ev;
        ev.event_kind    = kind;
        ev.content_byte  = (kind == KIND_CONTENT) ? ch : 8'h00;
        ev.column_number = column;
        ev.last_of_run   = 1'b0;
        expected_events.push_back(ev);
        emitted++;
    endfunction

    // Queues the events raised by one text transaction
    function automatic void tokenise(input t_in item);
        logic [7:0] c;
        logic       term;
        logic       quoted;
        c      = item.text_byte;
        term   = item.end_of_text || (c == CH_NUL);
        quoted = (mode == MODE_QUOTED);

        if (term) begin
            if (err_latched) begin
                emit(KIND_DONE, CH_NUL);
            end else if (quoted && !quote_pending) begin
                emit(KIND_UNTERMINATED, CH_NUL);
                emit(KIND_DONE, CH_NUL);
            end else begin
                if (column != 8'h00 || has_chars)
                    emit(KIND_FIELD_END, CH_NUL);
                emit(KIND_DONE, CH_NUL);
            end
            clear_parse_state();
            return;
        end
        if (err_latched)
            return;
        if (skip_lf) begin
            skip_lf = 1'b0;
            if (c == CH_LF)
                return;
        end
        if (quote_pending) begin
            quote_pending = 1'b0;
            if (c == CH_QUOTE) begin
                has_chars = 1'b1;
                emit(KIND_CONTENT, CH_QUOTE);
                return;
            end
            mode   = MODE_CLOSED;
            quoted = 1'b0;
        end
        if (quoted) begin
            if (c == CH_QUOTE) begin
                quote_pending = 1'b1;
            end else begin
                has_chars = 1'b1;
                emit(KIND_CONTENT, c);
            end
            return;
        end
        if (c == CH_QUOTE && mode != MODE_CLOSED && !has_chars) begin
            mode = MODE_QUOTED;
            return;
        end
        if (c == CH_COMMA) begin
            emit(KIND_FIELD_END, CH_NUL);
            if (column != COL_MAX)
                column = column + 8'd1;
            has_chars = 1'b0;
            mode      = MODE_OPEN;
        end else if (c == CH_CR || c == CH_LF) begin
            if (column != 8'h00 || has_chars) begin
                emit(KIND_FIELD_END, CH_NUL);
                emit(KIND_RECORD_END, CH_NUL);
            end
            column    = 8'h00;
            has_chars = 1'b0;
            mode      = MODE_OPEN;
            if (c == CH_CR)
                skip_lf = 1'b1;
        end else if (mode == MODE_CLOSED || c == CH_QUOTE) begin
            emit(KIND_MALFORMED, CH_NUL);
            err_latched = 1'b1;
        end else begin
            has_chars = 1'b1;
            emit(KIND_CONTENT, c);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse_state();
            expected_events.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                emitted = 0;
                tokenise(i_in_data);
                if (emitted != 0)
                    expected_events[expected_events.size() - 1].last_of_run = 1'b1;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    $display("%0t ns: extra event, expected none, actual %p",
                             $time, i_out_data);
                    fails++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", want.event_kind, i_out_data.event_kind);
                    check_field("content_byte", want.content_byte, i_out_data.content_byte);
                    check_field("column_number", want.column_number,
                                i_out_data.column_number);
                    check_field("last_of_run", want.last_of_run, i_out_data.last_of_run);
                end
            end
        end
        o_events_outstanding <= expected_events.size();
        o_fail_count         <= fails;
    end

endmodule

FILE: dv/tb_csv_record_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csv_record_tokenizer: regression bench for the CSV record tokeniser
// Sends a short directed text covering quoting, doubled quotes, line ends,
// empty records and errors, then random documents of mostly well-formed
// records with some broken ones and some noise, under bursty input and
// patterned output back-pressure. Checking is done by csv_event_checker.
// ----------------------------------------------------------------------------
module tb_csv_record_tokenizer
    import csvt_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in         in_data   = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    t_out        out_data;

    int unsigned fail_count;
    int unsigned events_outstanding;
    logic [31:0] cycle_count = '0;
    t_stall_mode stall_mode  = STALL_NONE;

    t_in         text_q[$];
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned random_base;

    always #4 clk = ~clk;

    csv_record_tokenizer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    csv_event_checker checker_inst (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_stall           (in_stall),
        .i_in_data            (in_data),
        .i_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .i_out_data           (out_data),
        .o_fail_count         (fail_count),
        .o_events_outstanding (events_outstanding)
    );

    // Receiver back-pressure in one of four patterns, picked at random
    always @(posedge clk) begin
        cycle_count <= cycle_count + 32'd1;
        if (cycle_count[6:0] == 7'd0)
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= (cycle_count[2:0] < 3'd3);
        endcase
        if (cycle_count == CYCLE_LIMIT) begin
            $display("csv_record_tokenizer regression: fail");
            $finish;
        end
    end

    function automatic void push_item(input logic [7:0] b, input logic eot);
        t_in item;
        item.text_byte   = b;
        item.end_of_text = eot;
        text_q.push_back(item);
    endfunction

    function automatic void push_term();
        if ($urandom_range(0, 1) == 0)
            push_item(8'($urandom_range(0, 255)), 1'b1);
        else
            push_item(CH_NUL, 1'b0);
    endfunction

    // Any byte that is neither a terminator nor a CSV control character
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic void add_field(input bit sparse);
        int unsigned len;
        int unsigned r;
        r   = $urandom_range(0, 9);
        len = $urandom_range(0, 6);
        if (sparse && $urandom_range(0, 9) != 0)
            return;
        if (r < 2) begin
            return;
        end else if (r < 5) begin
            push_item(CH_QUOTE, 1'b0);
            repeat (len) begin
                case ($urandom_range(0, 9))
                    0: begin
                        push_item(CH_QUOTE, 1'b0);
                        push_item(CH_QUOTE, 1'b0);
                    end
                    1: push_item(CH_COMMA, 1'b0);
                    2: push_item(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF, 1'b0);
                    default: push_item(plain_char(), 1'b0);
                endcase
            end
            push_item(CH_QUOTE, 1'b0);
        end else begin
            repeat (len + 1) push_item(plain_char(), 1'b0);
        end
    endfunction

    function automatic void add_line_end();
        case ($urandom_range(0, 2))
            0: push_item(CH_LF, 1'b0);
            1: push_item(CH_CR, 1'b0);
            default: begin
                push_item(CH_CR, 1'b0);
                push_item(CH_LF, 1'b0);
            end
        endcase
    endfunction

    // One record that ends in an error; the document is closed after it
    function automatic void add_broken_record();
        add_field(1'b0);
        if ($urandom_range(0, 1) != 0)
            push_item(CH_COMMA, 1'b0);
        case ($urandom_range(0, 2))
            0: begin
                push_item(plain_char(), 1'b0);
                push_item(CH_QUOTE, 1'b0);
            end
            1: begin
                push_item(CH_QUOTE, 1'b0);
                push_item(plain_char(), 1'b0);
                push_item(CH_QUOTE, 1'b0);
                push_item(plain_char(), 1'b0);
            end
            default: begin
                push_item(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 4)) push_item(plain_char(), 1'b0);
            end
        endcase
        repeat ($urandom_range(0, 3)) push_item(plain_char(), 1'b0);
    endfunction

    function automatic void add_document(input bit wide);
        int unsigned n_rec;
        int unsigned n_fld;
        bit          wide_rec;
        if (!wide && $urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(3, 12))
                push_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            push_term();
            return;
        end
        n_rec = $urandom_range(1, 4);
        for (int r = 0; r < n_rec; r++) begin
            if (!wide && $urandom_range(0, 7) == 0) begin
                add_broken_record();
                push_term();
                return;
            end
            wide_rec = wide && (r == 0);
            n_fld    = wide_rec ? 258 : $urandom_range(1, 5);
            for (int f = 0; f < n_fld; f++) begin
                add_field(wide_rec);
                if (f != n_fld - 1)
                    push_item(CH_COMMA, 1'b0);
            end
            if (r != n_rec - 1 || $urandom_range(0, 2) != 0)
                add_line_end();
        end
        push_term();
    endfunction

    task automatic send_text();
        t_in         item;
        int unsigned gap;
        while (text_q.size() != 0) begin
            item = text_q.pop_front();
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 24);
            end
            burst_left--;
            in_valid <= 1'b1;
            in_data  <= item;
            do @(posedge clk); while (in_stall);
            items_sent++;
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (events_outstanding != 0);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed text
        push_item(CH_NUL, 1'b0);
        push_item(8'hFF, 1'b0);    push_item(CH_COMMA, 1'b0);
        push_item(CH_QUOTE, 1'b0); push_item(8'h78, 1'b0);
        push_item(CH_QUOTE, 1'b0); push_item(CH_QUOTE, 1'b0);
        push_item(CH_QUOTE, 1'b0); push_item(CH_CR, 1'b0);
        push_item(CH_LF, 1'b0);    push_item(8'h01, 1'b0);
        push_item(CH_LF, 1'b0);
        // empty records, then a quote pending at the terminator
        push_item(CH_CR, 1'b0);    push_item(CH_CR, 1'b0);
        push_item(CH_COMMA, 1'b0); push_item(CH_QUOTE, 1'b0);
        push_item(CH_QUOTE, 1'b0); push_item(8'hFF, 1'b1);
        // unterminated quote
        push_item(CH_QUOTE, 1'b0); push_item(8'h61, 1'b0);
        push_item(CH_NUL, 1'b0);
        // stray quote in an unquoted field, error held until the terminator
        push_item(8'h62, 1'b0);    push_item(CH_QUOTE, 1'b0);
        push_item(8'h63, 1'b0);    push_item(CH_NUL, 1'b1);
        // junk after a closing quote
        push_item(CH_QUOTE, 1'b0); push_item(CH_QUOTE, 1'b0);
        push_item(8'h7A, 1'b0);    push_item(8'h80, 1'b1);
        send_text();
        wait_drain();

        random_base = items_sent;
        add_document(1'b1);
        send_text();
        while (items_sent - random_base < RANDOM_ITEMS) begin
            add_document(($urandom_range(0, 39) == 0));
            send_text();
            if ($urandom_range(0, 9) == 0)
                wait_drain();
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && events_outstanding == 0)
            $display("csv_record_tokenizer regression: pass");
        else
            $display("csv_record_tokenizer regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/csvt_pkg.sv
rtl/csvt_front.sv
rtl/csvt_queue.sv
rtl/csvt_back.sv
rtl/csv_record_tokenizer.sv
dv/csv_event_checker.sv
dv/tb_csv_record_tokenizer.sv
